@@ design/bsb_pkg.sv @@
// Shared types and constants for the bounding sphere builder.
package bsb_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_W          = 24;
  localparam int unsigned DIST_W           = 2 * COORD_W;
  localparam int unsigned ROOT_W           = COORD_W + 1;
  localparam int unsigned RADIUS_W         = 24;
  localparam int unsigned MARGIN_SHIFT     = 13;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RADIUS_W-1:0]       radius;
    logic                      overflow;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // vertex request accepted this cycle
    logic center;      // form center, rewind scan, clear best distance
    logic scan;        // issue one store read
    logic sqrt_start;  // launch the root unit on the best distance
    logic finish;      // load result register, clear mesh state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;   // current read address is the last stored vertex
    logic pipe_empty;  // no read in flight in the distance pipe
    logic sqrt_done;   // root result ready
  } sts_t;

endpackage

@@ design/bounding_sphere_builder.sv @@
// Top level of the bounding sphere builder: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     bsb_pkg::in_t  (x, y, z, last)
//   out_     output     out_valid / out_ready   bsb_pkg::out_t (center, radius, overflow)
//
// A vertex request is taken every cycle while the mesh loads. The request marked
// last starts the sphere pass over the N stored vertices: the center is formed,
// the N store reads go through the single read port, the distance pipe drains,
// the root unit is launched and works two operand bits per cycle until it raises
// its done flag, and then the result register is loaded.
// rst_n is synchronous and active low; it empties the mesh and the result slot.
// A waiting result never blocks loading of the next mesh; only the end of that
// mesh's pass waits for the result register to be taken.
module bounding_sphere_builder #(
  parameter int unsigned MAX_VERTICES = bsb_pkg::MAX_VERTICES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bsb_pkg::out_t out_data
);
  import bsb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the load, scan, root and result phases
  bsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the vertices, track bounds, find the farthest one and its root
  bsb_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // root unit must see the final best distance
  a_root_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |-> sts.pipe_empty)
    else $error("root started with reads still in flight");

  // a new result only comes from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result raised without a finish step");

  // no vertex enters while the store is being scanned
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !in_ready)
    else $error("input open during scan");

  // a finish step always presents a result in the next cycle
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finish did not present a result");
`endif

endmodule

@@ design/bsb_isqrt.sv @@
// Iterative ceiling square root, two operand bits per cycle.
module bsb_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsb_pkg::DIST_W-1:0]  operand,
  output logic                        done,
  output logic [bsb_pkg::ROOT_W-1:0]  result
);
  import bsb_pkg::*;

  localparam int unsigned ITER  = DIST_W / 2;
  localparam int unsigned CNT_W = $clog2(ITER);
  localparam int unsigned REM_W = ITER + 2;

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIST_W-1:0]   op_r;
  logic [REM_W-1:0]    rem_r;
  logic [ITER-1:0]     root_r;

  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                ge;
  logic [REM_W+1:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem_r, op_r[DIST_W-1 -: 2]};
    trial   = {{(REM_W + 2 - ITER - 2){1'b0}}, root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_sub = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r   <= {op_r[DIST_W-3:0], 2'b00};
      rem_r  <= rem_sub[REM_W-1:0];
      root_r <= {root_r[ITER-2:0], ge};
    end
  end

  // round up whenever a remainder is left
  assign result = ROOT_W'(root_r) + ROOT_W'(rem_r != '0);
  assign done   = done_r;

endmodule

@@ design/bsb_dp.sv @@
// Datapath: vertex store, min/max tracking, distance pipe and result register.
module bsb_dp #(
  parameter int unsigned MAX_VERTICES = bsb_pkg::MAX_VERTICES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bsb_pkg::cmd_t cmd,
  input  bsb_pkg::in_t  in_data,
  output bsb_pkg::sts_t sts,
  output bsb_pkg::out_t out_data
);
  import bsb_pkg::*;

  localparam int unsigned ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  function automatic logic [COORD_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

  function automatic coord_t midpoint(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

  vtx_t             mem [MAX_VERTICES];
  vtx_t             rd_r;

  logic [CNT_W-1:0]  count_r;
  logic              overflowed_r;
  logic [ADDR_W-1:0] addr_r;
  coord_t            low_x_r, low_y_r, low_z_r;
  coord_t            high_x_r, high_y_r, high_z_r;
  coord_t            cx_r, cy_r, cz_r;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [COORD_W-1:0] dx_r, dy_r, dz_r;
  logic [DIST_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0]  sum_r;
  logic [DIST_W-1:0]  best_r;

  logic              full;
  logic              first;
  logic              wr_en;
  logic              sq_done;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   rad_wide;
  logic [RADIUS_W-1:0] radius;
  out_t              out_r;

  assign full  = (count_r == CNT_W'(MAX_VERTICES));
  assign first = (count_r == '0);
  assign wr_en = cmd.take && !full;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= '{x: in_data.x, y: in_data.y, z: in_data.z};
    end
    rd_r <= mem[addr_r];
  end

  // mesh bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      overflowed_r <= 1'b0;
    end else if (cmd.finish) begin
      count_r      <= '0;
      overflowed_r <= 1'b0;
    end else if (cmd.take) begin
      if (full) overflowed_r <= 1'b1;
      else      count_r      <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      low_x_r  <= '0; low_y_r  <= '0; low_z_r  <= '0;
      high_x_r <= '0; high_y_r <= '0; high_z_r <= '0;
    end else if (cmd.take) begin
      if (first) begin
        low_x_r  <= in_data.x; low_y_r  <= in_data.y; low_z_r  <= in_data.z;
        high_x_r <= in_data.x; high_y_r <= in_data.y; high_z_r <= in_data.z;
      end else begin
        if (in_data.x < low_x_r)  low_x_r  <= in_data.x;
        if (in_data.y < low_y_r)  low_y_r  <= in_data.y;
        if (in_data.z < low_z_r)  low_z_r  <= in_data.z;
        if (in_data.x > high_x_r) high_x_r <= in_data.x;
        if (in_data.y > high_y_r) high_y_r <= in_data.y;
        if (in_data.z > high_z_r) high_z_r <= in_data.z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.center) begin
      cx_r <= midpoint(low_x_r, high_x_r);
      cy_r <= midpoint(low_y_r, high_y_r);
      cz_r <= midpoint(low_z_r, high_z_r);
    end
  end

  // scan address
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.center) begin
      addr_r <= '0;
    end else if (cmd.scan) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
  end

  // distance pipe: read, difference, square, sum, compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= abs_diff(rd_r.x, cx_r);
    dy_r  <= abs_diff(rd_r.y, cy_r);
    dz_r  <= abs_diff(rd_r.z, cz_r);
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    sqz_r <= dz_r * dz_r;
    sum_r <= sqx_r + sqy_r + sqz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.center) begin
      best_r <= '0;
    end else if (v4_r && (sum_r > best_r)) begin
      best_r <= sum_r;
    end
  end

  bsb_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (best_r),
    .done    (sq_done),
    .result  (root)
  );

  // add the 1/8192 margin, hold at full scale
  always_comb begin
    rad_wide = {1'b0, root} + (ROOT_W + 1)'(root >> MARGIN_SHIFT);
    radius   = (rad_wide > (ROOT_W + 1)'({RADIUS_W{1'b1}})) ? {RADIUS_W{1'b1}}
                                                           : rad_wide[RADIUS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.center_x <= cx_r;
      out_r.center_y <= cy_r;
      out_r.center_z <= cz_r;
      out_r.radius   <= radius;
      out_r.overflow <= overflowed_r;
    end
  end

  assign out_data       = out_r;
  assign sts.scan_last  = (CNT_W'(addr_r) == (count_r - CNT_W'(1)));
  assign sts.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);
  assign sts.sqrt_done  = sq_done;

endmodule

@@ design/bsb_ctrl.sv @@
// Controller: load, scan and root sequencing plus the handshakes.
module bsb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bsb_pkg::sts_t sts,
  output bsb_pkg::cmd_t cmd
);
  import bsb_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_CENTER = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_SQRT   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.take       = in_valid && in_ready;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      ST_LOAD: begin
        if (cmd.take && in_last) state_nxt = ST_CENTER;
      end
      ST_CENTER: begin
        cmd.center = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
